// ===== rtl/core/wsdf_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
// Holds result kinds, error codes, opcodes and header field masks.
// No dependencies.
package wsdf_pkg;

   // result kinds
   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_EMPTY   = 2'd2,
      KIND_ERROR   = 2'd3
   } kind_type;

   // error codes, first one is sticky
   localparam logic [3:0] ERR_NONE        = 4'd0;
   localparam logic [3:0] ERR_RSV_UNMASK  = 4'd1;
   localparam logic [3:0] ERR_OPCODE      = 4'd2;
   localparam logic [3:0] ERR_LEN_MSB     = 4'd3;
   localparam logic [3:0] ERR_FRAME_LIMIT = 4'd4;
   localparam logic [3:0] ERR_CTRL_SIZE   = 4'd5;
   localparam logic [3:0] ERR_CTRL_FRAG   = 4'd6;
   localparam logic [3:0] ERR_ORPHAN_CONT = 4'd7;
   localparam logic [3:0] ERR_INTERRUPTED = 4'd8;
   localparam logic [3:0] ERR_MSG_LIMIT   = 4'd9;

   // frame opcodes
   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   // header byte fields
   localparam logic [7:0] HDR_FIN_MASK   = 8'h80;
   localparam logic [7:0] HDR_RSV_MASK   = 8'h70;
   localparam logic [7:0] HDR_OP_MASK    = 8'h0F;
   localparam logic [7:0] HDR_LEN_MASK   = 8'h7F;
   localparam logic [6:0] LEN_EXT16      = 7'd126;
   localparam logic [6:0] LEN_EXT64      = 7'd127;
   localparam logic [63:0] CTRL_MAX_LEN  = 64'd125;
   localparam logic [3:0] EXT16_BYTES    = 4'd2;
   localparam logic [3:0] EXT64_BYTES    = 4'd8;

   // register map
   localparam int unsigned CSR_ADDR_W     = 3;
   localparam logic        REG_MAX_MSG    = 1'b0;
   localparam logic [31:0] MAX_MSG_RESET  = 32'd1048576;

endpackage

// ===== rtl/core/websocket_frame_deframer_top.sv =====
// WebSocket frame deframer, client-to-server direction: header parse,
// unmasking, opcode tagging and protocol checks, one result per byte.
// Depends on wsdf_pkg.
//
//  channel | ports                         | direction | transaction
//  --------+-------------------------------+-----------+-------------------------
//  req     | req_valid/req_ready/req_*     | in        | one raw stream byte
//  rsp     | rsp_valid/rsp_ready/rsp_*     | out       | one result per byte
//  csr     | psel/penable/pwrite/paddr/... | in/out    | APB write/read of limit
//
// Flow: one byte per cycle sustained while rsp_ready is high; a taken byte
// passes through the input register, then the result register.
// All decode and checks of a byte run between the input register and the
// result register; the per-byte path is set by the 64-bit length decrement
// and the message length add and compare.
// Reset: synchronous, active high; no clearing pass, ready right after reset.
// Stalls: a held result stalls the pipeline; req_ready drops only when both
// the input and the result registers are full and rsp_ready is low.
module websocket_frame_deframer_top
   import wsdf_pkg::*;
#(
   parameter int unsigned MESSAGE_COUNT_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // input byte stream
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_byte_in,
   // result stream
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_kind,
   output logic [7:0]            rsp_data_byte,
   output logic [3:0]            rsp_msg_opcode,
   output logic                  rsp_frame_last,
   output logic                  rsp_message_last,
   output logic [3:0]            rsp_fault_code,
   // configuration
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int unsigned SUM_W =
      ((MESSAGE_COUNT_BITS > 32) ? MESSAGE_COUNT_BITS : 32) + 1;

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXT,
      PH_MASK,
      PH_PAYLOAD,
      PH_ERR
   } phase_type;

   // pipeline and state registers
   logic                          in_valid_ff;
   logic [7:0]                    in_byte_ff;
   logic                          rsp_valid_ff;
   logic [1:0]                    kind_ff;
   logic [7:0]                    data_ff;
   logic [3:0]                    op_ff;
   logic                          flast_ff;
   logic                          mlast_ff;
   logic [3:0]                    err_ff;

   phase_type                     phase_ff, phase_in;
   logic                          fin_ff, fin_in;
   logic [3:0]                    frame_op_ff, frame_op_in;
   logic [3:0]                    ext_left_ff, ext_left_in;
   logic [63:0]                   remain_ff, remain_in;
   logic [31:0]                   mask_key_ff, mask_key_in;
   logic [1:0]                    mask_idx_ff, mask_idx_in;
   logic [3:0]                    open_op_ff, open_op_in;
   logic [MESSAGE_COUNT_BITS-1:0] total_ff, total_in;
   logic [3:0]                    sticky_ff, sticky_in;
   logic [31:0]                   max_msg_ff;

   // result of the current byte
   logic [1:0]  kind_in;
   logic [7:0]  data_in;
   logic [3:0]  op_in;
   logic        flast_in;
   logic        mlast_in;
   logic [3:0]  err_in;

   logic        advance;
   logic        fire;
   logic        csr_write;

   // length-complete checks
   logic [63:0]    acc_len;
   logic           is_ctrl;
   logic           len_over_max;
   logic [SUM_W-1:0] msg_sum;
   logic           sum_over;
   logic [3:0]     acc_err;

   // work fields of the byte step
   logic [3:0]  step_err;
   logic [1:0]  step_kind;
   logic        step_done;
   logic [7:0]  step_data;
   logic [7:0]  key_byte;
   logic [63:0] remain_dec;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;

   assign rsp_kind         = kind_ff;
   assign rsp_data_byte    = data_ff;
   assign rsp_msg_opcode   = op_ff;
   assign rsp_frame_last   = flast_ff;
   assign rsp_message_last = mlast_ff;
   assign rsp_fault_code   = err_ff;

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite &&
                      (paddr[CSR_ADDR_W-1] == REG_MAX_MSG);

   always_comb begin
      prdata = 32'd0;
      if (paddr[CSR_ADDR_W-1] == REG_MAX_MSG) begin
         prdata = max_msg_ff;
      end
   end

   // length as completed by this byte: short form or last extended byte
   always_comb begin
      if (phase_ff == PH_HDR1) begin
         acc_len = {57'd0, in_byte_ff[6:0]};
      end else begin
         acc_len = {remain_ff[55:0], in_byte_ff};
      end
   end

   // frame limit, control frame, continuation and message limit checks on a completed length
   assign is_ctrl      = frame_op_ff[3];
   assign len_over_max = (|acc_len[63:32]) || (acc_len[31:0] > max_msg_ff);
   assign msg_sum      = SUM_W'(total_ff) + SUM_W'(acc_len[31:0]);
   assign sum_over     = (msg_sum > SUM_W'(max_msg_ff)) ||
                         (|msg_sum[SUM_W-1:MESSAGE_COUNT_BITS]);

   always_comb begin
      acc_err = ERR_NONE;
      if (len_over_max) begin
         acc_err = ERR_FRAME_LIMIT;
      end else if (is_ctrl && (acc_len > CTRL_MAX_LEN)) begin
         acc_err = ERR_CTRL_SIZE;
      end else if (is_ctrl && !fin_ff) begin
         acc_err = ERR_CTRL_FRAG;
      end else if (!is_ctrl) begin
         if ((frame_op_ff == OP_CONT) && (open_op_ff == OP_CONT)) begin
            acc_err = ERR_ORPHAN_CONT;
         end else if ((frame_op_ff != OP_CONT) && (open_op_ff != OP_CONT)) begin
            acc_err = ERR_INTERRUPTED;
         end else if (sum_over) begin
            acc_err = ERR_MSG_LIMIT;
         end
      end
   end

   // select the key byte for this payload position
   always_comb begin
      case (mask_idx_ff)
         2'd0:    key_byte = mask_key_ff[31:24];
         2'd1:    key_byte = mask_key_ff[23:16];
         2'd2:    key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase
   end

   assign remain_dec = remain_ff - 64'd1;

   // byte step: next state and result
   always_comb begin
      phase_in    = phase_ff;
      fin_in      = fin_ff;
      frame_op_in = frame_op_ff;
      ext_left_in = ext_left_ff;
      remain_in   = remain_ff;
      mask_key_in = mask_key_ff;
      mask_idx_in = mask_idx_ff;
      open_op_in  = open_op_ff;
      total_in    = total_ff;
      sticky_in   = sticky_ff;
      step_err    = ERR_NONE;
      step_kind   = KIND_HEADER;
      step_done   = 1'b0;
      step_data   = 8'd0;
      kind_in     = KIND_HEADER;
      data_in     = 8'd0;
      op_in       = 4'd0;
      flast_in    = 1'b0;
      mlast_in    = 1'b0;
      err_in      = ERR_NONE;

      if (sticky_ff == ERR_NONE) begin
         case (phase_ff)
            PH_HDR1: begin
               if ((in_byte_ff & HDR_FIN_MASK) == 8'd0) begin
                  step_err = ERR_RSV_UNMASK;
               end else if (!((frame_op_ff == OP_CONT) || (frame_op_ff == OP_TEXT) ||
                              (frame_op_ff == OP_BINARY) || (frame_op_ff == OP_CLOSE) ||
                              (frame_op_ff == OP_PING) || (frame_op_ff == OP_PONG))) begin
                  step_err = ERR_OPCODE;
               end else if (in_byte_ff[6:0] == LEN_EXT16) begin
                  ext_left_in = EXT16_BYTES;
                  remain_in   = 64'd0;
                  phase_in    = PH_EXT;
               end else if (in_byte_ff[6:0] == LEN_EXT64) begin
                  ext_left_in = EXT64_BYTES;
                  remain_in   = 64'd0;
                  phase_in    = PH_EXT;
               end else begin
                  remain_in = acc_len;
                  step_err  = acc_err;
               end
            end
            PH_EXT: begin
               if ((ext_left_ff == EXT64_BYTES) && in_byte_ff[7]) begin
                  step_err = ERR_LEN_MSB;
               end else begin
                  remain_in   = acc_len;
                  ext_left_in = ext_left_ff - 4'd1;
                  if (ext_left_ff == 4'd1) begin
                     step_err = acc_err;
                  end
               end
            end
            PH_MASK: begin
               mask_key_in = {mask_key_ff[23:0], in_byte_ff};
               mask_idx_in = mask_idx_ff + 2'd1;
               if (mask_idx_ff == 2'd3) begin
                  if (remain_ff == 64'd0) begin
                     step_done = 1'b1;
                     step_kind = KIND_EMPTY;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               step_data   = in_byte_ff ^ key_byte;
               mask_idx_in = mask_idx_ff + 2'd1;
               remain_in   = remain_dec;
               step_kind   = KIND_PAYLOAD;
               step_done   = (remain_dec == 64'd0);
            end
            PH_HDR0: begin
               fin_in      = in_byte_ff[7];
               frame_op_in = in_byte_ff[3:0] & HDR_OP_MASK[3:0];
               if ((in_byte_ff & HDR_RSV_MASK) != 8'd0) begin
                  step_err = ERR_RSV_UNMASK;
               end else begin
                  phase_in = PH_HDR1;
               end
            end
            default: begin
               phase_in = PH_ERR;
            end
         endcase

         // length accepted: open message, arm the mask key
         if (((phase_ff == PH_HDR1) && (in_byte_ff[6:0] != LEN_EXT16) &&
              (in_byte_ff[6:0] != LEN_EXT64) && (step_err == ERR_NONE) &&
              in_byte_ff[7]) ||
             ((phase_ff == PH_EXT) && (ext_left_ff == 4'd1) &&
              (step_err == ERR_NONE))) begin
            if (!is_ctrl) begin
               if (frame_op_ff != OP_CONT) begin
                  open_op_in = frame_op_ff;
               end
               total_in = msg_sum[MESSAGE_COUNT_BITS-1:0];
            end
            phase_in    = PH_MASK;
            mask_key_in = 32'd0;
            mask_idx_in = 2'd0;
         end

         // tag payload and frame completions
         if (step_kind != KIND_HEADER) begin
            kind_in = step_kind;
            data_in = step_data;
            op_in   = is_ctrl ? frame_op_ff : open_op_ff;
            if (step_done) begin
               flast_in = 1'b1;
               phase_in = PH_HDR0;
               if (is_ctrl) begin
                  mlast_in = 1'b1;
                  if (frame_op_ff == OP_CLOSE) begin
                     open_op_in = OP_CONT;
                     total_in   = '0;
                  end
               end else if (fin_ff) begin
                  mlast_in   = 1'b1;
                  open_op_in = OP_CONT;
                  total_in   = '0;
               end
            end
            // absorb pong payload
            if (frame_op_ff == OP_PONG) begin
               kind_in  = KIND_HEADER;
               data_in  = 8'd0;
               op_in    = 4'd0;
               flast_in = 1'b0;
               mlast_in = 1'b0;
            end
         end

         if (step_err != ERR_NONE) begin
            sticky_in = step_err;
            phase_in  = PH_ERR;
         end
      end

      // report the sticky error
      if (sticky_in != ERR_NONE) begin
         kind_in  = KIND_ERROR;
         data_in  = 8'd0;
         op_in    = 4'd0;
         flast_in = 1'b0;
         mlast_in = 1'b0;
         err_in   = sticky_in;
      end
   end

   // hold state, pipeline and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_HDR0;
         fin_ff       <= 1'b0;
         frame_op_ff  <= 4'd0;
         ext_left_ff  <= 4'd0;
         remain_ff    <= 64'd0;
         mask_key_ff  <= 32'd0;
         mask_idx_ff  <= 2'd0;
         open_op_ff   <= OP_CONT;
         total_ff     <= '0;
         sticky_ff    <= ERR_NONE;
         max_msg_ff   <= MAX_MSG_RESET;
      end else begin
         if (csr_write) begin
            max_msg_ff <= pwdata;
         end
         // input register
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
            in_byte_ff  <= req_byte_in;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         // result register
         if (fire) begin
            rsp_valid_ff <= 1'b1;
            kind_ff      <= kind_in;
            data_ff      <= data_in;
            op_ff        <= op_in;
            flast_ff     <= flast_in;
            mlast_ff     <= mlast_in;
            err_ff       <= err_in;
            phase_ff     <= phase_in;
            fin_ff       <= fin_in;
            frame_op_ff  <= frame_op_in;
            ext_left_ff  <= ext_left_in;
            remain_ff    <= remain_in;
            mask_key_ff  <= mask_key_in;
            mask_idx_ff  <= mask_idx_in;
            open_op_ff   <= open_op_in;
            total_ff     <= total_in;
            sticky_ff    <= sticky_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // an error once raised never changes
   a_sticky_hold: assert property (@(posedge clock) disable iff (reset)
      (sticky_ff != ERR_NONE) |=> (sticky_ff == $past(sticky_ff)))
      else $error("sticky error changed");

   // an error result always carries a code
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_ERROR)) |-> (rsp_fault_code != ERR_NONE))
      else $error("error result without code");

   // delivered payload belongs to an open message or a control frame
   a_payload_op: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_PAYLOAD)) |-> (rsp_msg_opcode != OP_CONT))
      else $error("payload byte without message opcode");

   // payload phase always has bytes left
   a_remain: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (remain_ff != 64'd0))
      else $error("payload phase with nothing remaining");

endmodule
